[rtl/surface_patch_association_table_defines.svh]
// ---------------------------------------------------------------------------
// Surface patch association table: assertion macros
// Shared property shorthands for the table's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SURFACE_PATCH_ASSOCIATION_TABLE_DEFINES_SVH
`define SURFACE_PATCH_ASSOCIATION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SPAT_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SPAT_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spat_pkg.sv]
// ---------------------------------------------------------------------------
// Surface patch association table package
// Item types, codes and fixed widths shared by the table and its channels.
// ---------------------------------------------------------------------------
`default_nettype none

package spat_pkg;

  // Fixed field widths
  localparam int DET_W    = 16;
  localparam int TOL_W    = 12;
  localparam int SQ_W     = 2 * TOL_W;
  localparam int PID_W    = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Register reset values, Q8.4 inches
  localparam logic [TOL_W-1:0] XY_TOL_RST = 12'd192;
  localparam logic [TOL_W-1:0] Z_TOL_RST  = 12'd48;

  typedef enum logic [OP_W-1:0] {
    OP_MATCH   = 2'd0,
    OP_SAVE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCHED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_ABSENT   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XY_TOL = 2'd0,
    REG_Z_TOL  = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [DET_W-1:0] det_x;
    logic signed [DET_W-1:0] det_y;
    logic signed [DET_W-1:0] det_z;
    logic signed [DET_W-1:0] det_offset;
    logic [PID_W-1:0]        release_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PID_W-1:0]    patch_id;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [TOL_W-1:0]     value;
  } cfg_item_t;

endpackage

`default_nettype wire

[rtl/spat_stream_if.sv]
// ---------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one item of the given payload type per handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface spat_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/spat_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module spat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/surface_patch_association_table.sv]
// ---------------------------------------------------------------------------
// Surface patch association table
// Matches detections against saved patches, blends or inserts, frees by id.
// ---------------------------------------------------------------------------
//
//  channel  dir  contents                                      accepted when
//  -------  ---  --------------------------------------------  -------------------
//  in_i     in   opcode, det_x/y/z, det_offset, release_id     valid && ready
//  out_o    out  status, slot, patch_id                        valid && ready
//  cfg_i    in   index (0 xy tolerance, 1 z tolerance), value  valid (ready tied)
//
//  Steps: take the item, square the xy tolerance, then per slot S_DIFF alone
//  (free slot or release), S_DIFF and S_SQX (occupied, outside the box) or
//  S_DIFF, S_SQX, S_SQY and S_ACC (occupied, inside the box), then write-back,
//  set by the single squarer and the single read port of the slot RAMs walking
//  the slots in turn. Opcode three goes straight from taking the item to write-back.
//  Reset clears the occupancy bits and the id counter and loads the tolerance
//  reset values; there is no clearing pass. A result waits in the output register
//  while the next item is taken; write-back holds only if that register is still full.
//
`default_nettype none

`include "surface_patch_association_table_defines.svh"

module surface_patch_association_table #(
  parameter int ENTRIES    = 8,
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spat_stream_if.sink   in_i,
  spat_stream_if.source out_o,
  spat_stream_if.sink   cfg_i
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int DW     = COORD_BITS + 1;
  localparam int ROW_W  = 4 * COORD_BITS;
  localparam int TOL_W  = spat_pkg::TOL_W;
  localparam int SQ_W   = spat_pkg::SQ_W;
  localparam int SLOT_W = spat_pkg::SLOT_W;
  localparam int PID_W  = spat_pkg::PID_W;
  localparam int CMP_W  = (ID_BITS > PID_W) ? ID_BITS : PID_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOL,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_ACC,
    S_WRITE
  } state_e;

  // Halfway average, rounded toward minus infinity
  function automatic logic [COORD_BITS-1:0] half_floor(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DW-1:0] s;
    s = DW'(a) + DW'(b);
    return s[DW-1:1];
  endfunction

  state_e                       state_q;
  spat_pkg::op_e                op_q;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q, off_q;
  logic [PID_W-1:0]             rid_q;
  logic [TOL_W-1:0]             xy_tol_q, z_tol_q;
  logic [SQ_W-1:0]              tol2_q;
  logic [IDX_W-1:0]             idx_q;
  logic [ENTRIES-1:0]           valid_q;
  logic [DW-1:0]                ax_q, ay_q, az_q;
  logic [SQ_W-1:0]              sqx_q, sqy_q;
  logic                         win_found_q;
  logic [IDX_W-1:0]             win_idx_q;
  logic [SQ_W:0]                best_d2_q;
  logic [ROW_W-1:0]             best_row_q;
  logic [ID_BITS-1:0]           best_id_q;
  logic                         free_found_q;
  logic [IDX_W-1:0]             free_idx_q;
  logic [ID_BITS-1:0]           id_ctr_q;
  logic                         out_valid_q;
  spat_pkg::out_item_t          out_data_q;

  // Slot RAM ports
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ROW_W-1:0]     row_rd;
  logic [ID_BITS-1:0]   id_rd;
  logic                 row_wr_en;
  logic                 id_wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ROW_W-1:0]     row_wr;

  // Datapath
  logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
  logic signed [COORD_BITS-1:0] bx, by, bz, boff;
  logic signed [DW-1:0]         dx, dy, dz;
  logic [DW-1:0]                ax, ay, az;
  logic [TOL_W-1:0]             mult_a;
  logic [SQ_W-1:0]              sq_prod;
  logic                         in_box;
  logic [SQ_W:0]                d2;
  logic                         qual, better;
  logic                         at_last, adv;
  logic                         out_free, fire;
  logic                         do_blend, do_insert;
  logic                         rel_hit;
  logic [ID_BITS-1:0]           id_inc, id_new;
  spat_pkg::out_item_t          res;

  // Handshakes
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = (state_q == S_WRITE) && out_free;

  // Slot fields out of the read row
  assign rd_x = row_rd[COORD_BITS-1:0];
  assign rd_y = row_rd[2*COORD_BITS-1:COORD_BITS];
  assign rd_z = row_rd[3*COORD_BITS-1:2*COORD_BITS];
  assign bx   = best_row_q[COORD_BITS-1:0];
  assign by   = best_row_q[2*COORD_BITS-1:COORD_BITS];
  assign bz   = best_row_q[3*COORD_BITS-1:2*COORD_BITS];
  assign boff = best_row_q[4*COORD_BITS-1:3*COORD_BITS];

  // Detection minus slot, magnitudes
  assign dx = DW'(x_q) - DW'(rd_x);
  assign dy = DW'(y_q) - DW'(rd_y);
  assign dz = DW'(z_q) - DW'(rd_z);
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign az = dz[DW-1] ? DW'(-dz) : DW'(dz);

  // Shared squarer: tolerance first, then dx and dy of each candidate
  always_comb begin
    unique case (state_q)
      S_TOL:   mult_a = xy_tol_q;
      S_SQX:   mult_a = ax_q[TOL_W-1:0];
      default: mult_a = ay_q[TOL_W-1:0];
    endcase
  end
  assign sq_prod = SQ_W'(mult_a) * SQ_W'(mult_a);

  assign in_box = (ax_q <= DW'(xy_tol_q)) && (ay_q <= DW'(xy_tol_q))
               && (az_q <= DW'(z_tol_q));
  assign d2     = (SQ_W + 1)'(sqx_q) + (SQ_W + 1)'(sqy_q);
  assign qual   = d2 <= (SQ_W + 1)'(tol2_q);
  assign better = !win_found_q || (d2 < best_d2_q);

  assign rel_hit = valid_q[idx_q] && (CMP_W'(id_rd) == CMP_W'(rid_q));

  // Step to the next slot, or finish the scan
  assign at_last = (idx_q == LAST_IDX);
  assign adv = ((state_q == S_DIFF)
                && ((op_q == spat_pkg::OP_RELEASE) || !valid_q[idx_q]))
            || ((state_q == S_SQX) && !in_box)
            || (state_q == S_ACC);

  assign rd_en   = (state_q == S_TOL) || (adv && !at_last);
  assign rd_addr = (state_q == S_TOL) ? '0 : idx_q + IDX_W'(1);

  // Write-back decisions
  assign do_blend  = ((op_q == spat_pkg::OP_MATCH) || (op_q == spat_pkg::OP_SAVE))
                  && win_found_q;
  assign do_insert = (op_q == spat_pkg::OP_SAVE) && !win_found_q && free_found_q;

  assign id_inc = id_ctr_q + ID_BITS'(1);
  assign id_new = (id_inc == '0) ? ID_BITS'(1) : id_inc;

  assign row_wr_en = fire && (do_blend || do_insert);
  assign id_wr_en  = fire && do_insert;
  assign wr_addr   = do_blend ? win_idx_q : free_idx_q;
  assign row_wr    = do_blend
                   ? {half_floor(boff, off_q), half_floor(bz, z_q),
                      half_floor(by, y_q), half_floor(bx, x_q)}
                   : {off_q, z_q, y_q, x_q};

  // Result item
  always_comb begin
    res        = '0;
    res.status = spat_pkg::ST_NOMATCH;
    priority if (op_q == spat_pkg::OP_RELEASE) begin
      if (win_found_q) begin
        res.status = spat_pkg::ST_RELEASED;
        res.slot   = SLOT_W'(win_idx_q);
      end else begin
        res.status = spat_pkg::ST_ABSENT;
      end
    end else if (do_blend) begin
      res.status   = spat_pkg::ST_MATCHED;
      res.slot     = SLOT_W'(win_idx_q);
      res.patch_id = PID_W'(best_id_q);
    end else if (do_insert) begin
      res.status   = spat_pkg::ST_INSERTED;
      res.slot     = SLOT_W'(free_idx_q);
      res.patch_id = PID_W'(id_new);
    end else if (op_q == spat_pkg::OP_SAVE) begin
      res.status = spat_pkg::ST_FULL;
    end else begin
      res.status = spat_pkg::ST_NOMATCH;
    end
  end

  // Slot position/offset rows and slot ids
  spat_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (row_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (row_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (row_rd)
  );

  spat_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (ENTRIES)
  ) u_id_ram (
    .clk_i     (clk_i),
    .wr_en_i   (id_wr_en),
    .wr_addr_i (free_idx_q),
    .wr_data_i (id_new),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (id_rd)
  );

  // Sequencer, table state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= spat_pkg::OP_NONE;
      x_q          <= '0;
      y_q          <= '0;
      z_q          <= '0;
      off_q        <= '0;
      rid_q        <= '0;
      xy_tol_q     <= spat_pkg::XY_TOL_RST;
      z_tol_q      <= spat_pkg::Z_TOL_RST;
      tol2_q       <= '0;
      idx_q        <= '0;
      valid_q      <= '0;
      ax_q         <= '0;
      ay_q         <= '0;
      az_q         <= '0;
      sqx_q        <= '0;
      sqy_q        <= '0;
      win_found_q  <= 1'b0;
      win_idx_q    <= '0;
      best_d2_q    <= '0;
      best_row_q   <= '0;
      best_id_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      id_ctr_q     <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // Tolerance registers
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          spat_pkg::REG_XY_TOL: xy_tol_q <= cfg_i.data.value;
          spat_pkg::REG_Z_TOL:  z_tol_q  <= cfg_i.data.value;
          default: ;
        endcase
      end

      // Result register: filled at write-back, emptied when taken
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q         <= spat_pkg::op_e'(in_i.data.opcode);
            x_q          <= COORD_BITS'(in_i.data.det_x);
            y_q          <= COORD_BITS'(in_i.data.det_y);
            z_q          <= COORD_BITS'(in_i.data.det_z);
            off_q        <= COORD_BITS'(in_i.data.det_offset);
            rid_q        <= in_i.data.release_id;
            win_found_q  <= 1'b0;
            free_found_q <= 1'b0;
            if (spat_pkg::op_e'(in_i.data.opcode) == spat_pkg::OP_NONE) begin
              state_q <= S_WRITE;
            end else begin
              state_q <= S_TOL;
            end
          end
        end
        S_TOL: begin
          tol2_q  <= sq_prod;
          idx_q   <= '0;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          if (op_q == spat_pkg::OP_RELEASE) begin
            if (rel_hit) begin
              valid_q[idx_q] <= 1'b0;
              if (!win_found_q) begin
                win_found_q <= 1'b1;
                win_idx_q   <= idx_q;
              end
            end
          end else if (!valid_q[idx_q]) begin
            if (!free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= idx_q;
            end
          end else begin
            ax_q    <= ax;
            ay_q    <= ay;
            az_q    <= az;
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          if (in_box) begin
            sqx_q   <= sq_prod;
            state_q <= S_SQY;
          end
        end
        S_SQY: begin
          sqy_q   <= sq_prod;
          state_q <= S_ACC;
        end
        S_ACC: begin
          // Nearest qualifying slot; lowest slot kept on a tie
          if (qual && better) begin
            win_found_q <= 1'b1;
            win_idx_q   <= idx_q;
            best_d2_q   <= d2;
            best_row_q  <= row_rd;
            best_id_q   <= id_rd;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_data_q  <= res;
            if (do_insert) begin
              id_ctr_q            <= id_new;
              valid_q[free_idx_q] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Common slot step
      if (adv) begin
        if (at_last) begin
          state_q <= S_WRITE;
        end else begin
          idx_q   <= idx_q + IDX_W'(1);
          state_q <= S_DIFF;
        end
      end
    end
  end

  // Checks
  `SPAT_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "item taken but still ready")
  `SPAT_ASSERT_IMP(a_blend_occupied, clk_i, rst_ni, (state_q == S_WRITE) && do_blend, valid_q[win_idx_q], "blend target slot is free")
  `SPAT_ASSERT_NXT(a_id_nonzero, clk_i, rst_ni, fire && do_insert, id_ctr_q != '0, "inserted id is zero")
  `SPAT_ASSERT_NXT(a_release_no_fill, clk_i, rst_ni, (state_q == S_DIFF) && (op_q == spat_pkg::OP_RELEASE), $countones(valid_q) <= $past($countones(valid_q)), "release filled a slot")

endmodule

`default_nettype wire
